### rtl/skfc_pkg.sv
package skfc_pkg;

    localparam int ENTRIES    = 64;
    localparam int KEY_BYTES  = 16;
    localparam int COUNT_BITS = 16;
    localparam int IDX_W      = $clog2(ENTRIES + 1);
    localparam int KLEN_W     = $clog2(KEY_BYTES + 1);
    localparam int OUT_CNT_W  = 16;
    localparam logic [7:0] DELIM_RESET = 8'd32;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    localparam logic [1:0] ST_NEW     = 2'd0;
    localparam logic [1:0] ST_COUNTED = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_DUMP = 1'b1;

    typedef struct packed {
        logic [63:0]           hi;
        logic [63:0]           lo;
        logic [COUNT_BITS-1:0] cnt;
    } entry_t;

    // broadcast from controller to every cell
    typedef struct packed {
        logic   insert;     // shift right from insert point and write new key
        logic   bump;       // increment the matching cell
        logic   rotate;     // shift left circularly during dump
        entry_t key;
    } cell_ctl_t;

    function automatic logic key_less(input logic [63:0] ah, input logic [63:0] al,
                                      input logic [63:0] bh, input logic [63:0] bl);
        return (ah < bh) || ((ah == bh) && (al < bl));
    endfunction

endpackage

### rtl/skfc_cell.sv
module skfc_cell
    import skfc_pkg::*;
(
    input  logic      clk,
    input  cell_ctl_t ctl,
    input  logic      valid,
    input  entry_t    left_entry,
    input  logic      left_less,
    input  entry_t    right_entry,
    input  logic      is_tail,
    input  entry_t    head_entry,
    output entry_t    entry,
    output logic      less,
    output logic      hit
);

    entry_t entry_reg;
    entry_t entry_next;

    assign entry = entry_reg;
    assign less  = valid && key_less(entry_reg.hi, entry_reg.lo, ctl.key.hi, ctl.key.lo);
    assign hit   = valid && (entry_reg.hi == ctl.key.hi) && (entry_reg.lo == ctl.key.lo);

    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.rotate)
        begin
            entry_next = is_tail ? head_entry : right_entry;
        end
        else if (ctl.bump && hit)
        begin
            if (entry_reg.cnt != COUNT_MAX)
            begin
                entry_next.cnt = entry_reg.cnt + 1'b1;
            end
        end
        else if (ctl.insert && !less)
        begin
            if (left_less)
            begin
                entry_next     = ctl.key;
                entry_next.cnt = COUNT_BITS'(1);
            end
            else
            begin
                entry_next = left_entry;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

### rtl/skfc_key_builder.sv
module skfc_key_builder
    import skfc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_en,
    input  logic        clear,
    input  logic [7:0]  byte_value,
    input  logic [7:0]  delimiter,
    output logic [63:0] key_hi,
    output logic [63:0] key_lo,
    output logic        truncated
);

    logic [KEY_BYTES*8-1:0] bytes_reg;
    logic [KLEN_W-1:0]      len_reg;
    logic                   closed_reg;
    logic                   ovf_reg;
    logic [127:0]           packed_key;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_reg  <= '0;
            len_reg    <= '0;
            closed_reg <= 1'b0;
            ovf_reg    <= 1'b0;
        end
        else if (clear)
        begin
            bytes_reg  <= '0;
            len_reg    <= '0;
            closed_reg <= 1'b0;
            ovf_reg    <= 1'b0;
        end
        else if (byte_en && !closed_reg)
        begin
            if (byte_value == delimiter)
            begin
                closed_reg <= 1'b1;
            end
            else if (len_reg < KLEN_W'(KEY_BYTES))
            begin
                bytes_reg[(KEY_BYTES-1-32'(len_reg))*8 +: 8] <= byte_value;
                len_reg <= len_reg + 1'b1;
            end
            else
            begin
                ovf_reg <= 1'b1;
            end
        end
    end

    assign packed_key = 128'(bytes_reg) << (8 * (16 - KEY_BYTES));
    assign key_hi     = packed_key[127:64];
    assign key_lo     = packed_key[63:0];
    assign truncated  = ovf_reg;

endmodule

### rtl/sorted_key_frequency_counter.sv
// Sorted key frequency counter.
// s_axis: requests; tdata = {line_end, byte_value}, tuser = req_type (1 = dump).
// A line end passes through a wait state, then looks the key up in a row of cells and
// updates it (count or sorted insert) in the update state, then shows one line status
// result. A dump rotates the used entries once around, one entry per cycle while the
// output is not stalled, and shows each one as a dump result; an empty table gives none.
// cfg: delimiter write, valid/ready, taken only when the block is idle.
// m_axis: results; tuser = result_kind, tlast = is_last, tdata from bit 0 up:
// line_status, key_truncated, key_high_word, key_low_word, occurrence_count.
// The output register holds a result while m_axis_tready is low; the block
// takes no further request until it is accepted.
// Reset empties the table, clears the partial key and sets delimiter to space.
module sorted_key_frequency_counter
    import skfc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [15:0]  s_axis_tdata,   // byte_value[7:0], line_end[8]
    input  logic         s_axis_tuser,   // req_type
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [7:0]   cfg_data,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [151:0] m_axis_tdata,   // line_status[1:0], key_truncated[2],
                                         // key_high_word[66:3], key_low_word[130:67],
                                         // occurrence_count[146:131]
    output logic         m_axis_tuser,   // result_kind
    output logic         m_axis_tlast    // is_last
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_UPDATE = 4'b0010,
        S_DUMP   = 4'b0100,
        S_WAIT   = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic [7:0]       delim_reg;
    logic [IDX_W-1:0] used_reg;
    logic [IDX_W-1:0] dump_cnt_reg;
    logic             out_valid_reg;
    logic [151:0]     out_data_reg;
    logic             out_kind_reg;
    logic             out_last_reg;

    logic [63:0] key_hi, key_lo;
    logic        trunc;
    logic        take, byte_en, clear_key;
    logic        any_hit;
    logic        full;
    cell_ctl_t   ctl;

    entry_t cell_entry [ENTRIES];
    logic   cell_less  [ENTRIES];
    logic   cell_hit   [ENTRIES];
    logic [COUNT_BITS-1:0] hit_cnt;

    assign s_axis_tready = (state_reg == S_IDLE) && !out_valid_reg;
    assign cfg_ready     = (state_reg == S_IDLE) && !out_valid_reg;
    assign take          = s_axis_tvalid && s_axis_tready;
    assign byte_en       = take && (s_axis_tuser == REQ_BYTE) && !s_axis_tdata[8];
    assign full          = (used_reg == IDX_W'(ENTRIES));

    skfc_key_builder u_key (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_en    (byte_en),
        .clear      (clear_key),
        .byte_value (s_axis_tdata[7:0]),
        .delimiter  (delim_reg),
        .key_hi     (key_hi),
        .key_lo     (key_lo),
        .truncated  (trunc)
    );

    always_comb
    begin
        any_hit = 1'b0;
        hit_cnt = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            any_hit = any_hit | cell_hit[i];
            hit_cnt = hit_cnt | (cell_hit[i] ? cell_entry[i].cnt : '0);
        end
    end

    assign ctl.key.hi  = key_hi;
    assign ctl.key.lo  = key_lo;
    assign ctl.key.cnt = '0;
    assign ctl.bump    = (state_reg == S_UPDATE) && any_hit;
    assign ctl.insert  = (state_reg == S_UPDATE) && !any_hit && !full;
    assign ctl.rotate  = (state_reg == S_DUMP) && (!out_valid_reg || m_axis_tready);
    assign clear_key   = (state_reg == S_UPDATE);

    for (genvar g = 0; g < ENTRIES; g++)
    begin : g_cell
        logic   valid_g;
        entry_t left_g;
        logic   left_less_g;
        assign valid_g     = IDX_W'(g) < used_reg;
        if (g == 0)
        begin : g_first
            assign left_g      = '0;
            assign left_less_g = 1'b1;
        end
        else
        begin : g_rest
            assign left_g      = cell_entry[g-1];
            assign left_less_g = cell_less[g-1];
        end
        skfc_cell u_cell (
            .clk         (clk),
            .ctl         (ctl),
            .valid       (valid_g),
            .left_entry  (left_g),
            .left_less   (left_less_g),
            .right_entry (cell_entry[(g+1) % ENTRIES]),
            .is_tail     (IDX_W'(g + 1) == used_reg),
            .head_entry  (cell_entry[0]),
            .entry       (cell_entry[g]),
            .less        (cell_less[g]),
            .hit         (cell_hit[g])
        );
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (take && s_axis_tuser == REQ_DUMP)
                begin
                    if (used_reg != '0)
                    begin
                        state_next = S_DUMP;
                    end
                end
                else if (take && s_axis_tdata[8])
                begin
                    state_next = S_WAIT;
                end
            end
            S_WAIT:   state_next = S_UPDATE;
            S_UPDATE: state_next = S_IDLE;
            S_DUMP:
            begin
                if (ctl.rotate && dump_cnt_reg == used_reg - 1'b1)
                begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    logic [COUNT_BITS-1:0] bumped;
    logic [OUT_CNT_W-1:0]  bumped_sat;
    logic [COUNT_BITS-1:0] head_cnt;
    logic [OUT_CNT_W-1:0]  head_sat;
    assign bumped     = (hit_cnt == COUNT_MAX) ? hit_cnt : hit_cnt + 1'b1;
    assign bumped_sat = (COUNT_BITS > OUT_CNT_W && bumped > COUNT_BITS'({OUT_CNT_W{1'b1}}))
                        ? '1 : OUT_CNT_W'(bumped);
    assign head_cnt   = cell_entry[0].cnt;
    assign head_sat   = (COUNT_BITS > OUT_CNT_W && head_cnt > COUNT_BITS'({OUT_CNT_W{1'b1}}))
                        ? '1 : OUT_CNT_W'(head_cnt);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            delim_reg     <= DELIM_RESET;
            used_reg      <= '0;
            dump_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                delim_reg <= cfg_data;
            end
            if (out_valid_reg && m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == S_IDLE)
            begin
                dump_cnt_reg <= '0;
            end
            if (state_reg == S_UPDATE)
            begin
                out_valid_reg <= 1'b1;
                if (ctl.insert)
                begin
                    used_reg <= used_reg + 1'b1;
                end
            end
            if (ctl.rotate)
            begin
                out_valid_reg <= 1'b1;
                dump_cnt_reg  <= dump_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_UPDATE)
        begin
            out_kind_reg <= 1'b0;
            out_last_reg <= 1'b1;
            out_data_reg <= {5'd0,
                             any_hit ? bumped_sat : (full ? OUT_CNT_W'(0) : OUT_CNT_W'(1)),
                             key_lo, key_hi, trunc,
                             any_hit ? ST_COUNTED : (full ? ST_FULL : ST_NEW)};
        end
        else if (ctl.rotate)
        begin
            out_kind_reg <= 1'b1;
            out_last_reg <= (dump_cnt_reg == used_reg - 1'b1);
            out_data_reg <= {5'd0, head_sat, cell_entry[0].lo, cell_entry[0].hi,
                             1'b0, ST_NEW};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule
